// ----- sv/quaternion_attitude_integrator_core_defines.svh -----
// Assertion macros for the quaternion attitude integrator
`ifndef QUATERNION_ATTITUDE_INTEGRATOR_CORE_DEFINES_SVH
`define QUATERNION_ATTITUDE_INTEGRATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define QAI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qai: same-cycle check failed");

`define QAI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qai: next-cycle check failed");

`else

`define QAI_ASSERT_NOW(lbl, ante, cons)

`define QAI_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- sv/qai_pkg.sv -----
// Types and constants shared by the quaternion attitude integrator
package qai_pkg;

  localparam int QUAT_W     = 32;
  localparam int RATE_W     = 24;
  localparam int DT_W       = 24;
  localparam int DT_FRAC_BITS = 24;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CNT_W      = 5;
  localparam int S_W        = 58;
  localparam int ACC_W      = 60;

  localparam logic [DT_W-1:0]            TIME_STEP_RST = 24'd167772;
  localparam logic [CNT_W-1:0]           LAST_STEP     = 5'd23;
  localparam logic signed [QUAT_W-1:0]   QUAT_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [QUAT_W-1:0]   QUAT_MIN      = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP = 3'd0,
    REG_INIT_W    = 3'd1,
    REG_INIT_X    = 3'd2,
    REG_INIT_Y    = 3'd3,
    REG_INIT_Z    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_SCALE,
    ST_SUM,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic                     op;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
  } in_word_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] att_w;
    logic signed [QUAT_W-1:0] att_x;
    logic signed [QUAT_W-1:0] att_y;
    logic signed [QUAT_W-1:0] att_z;
    logic                     saturated;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic rate_step;
    logic rate_last;
    logic scale_step;
    logic dt_bit;
  } lane_ctl_t;

  typedef struct packed {
    logic en;
    logic neg;
  } term_ctl_t;

endpackage

// ----- sv/qai_lane.sv -----
// Bit-serial multiply-accumulate lane for one quaternion component
module qai_lane
  import qai_pkg::*;
#(
  parameter int RATE_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  lane_ctl_t                ctl,
  input  logic signed [QUAT_W-1:0] op_a,
  input  logic signed [QUAT_W-1:0] op_b,
  input  logic signed [QUAT_W-1:0] op_c,
  input  term_ctl_t                term_a,
  input  term_ctl_t                term_b,
  input  term_ctl_t                term_c,
  input  logic signed [QUAT_W-1:0] old_q,
  output logic signed [QUAT_W-1:0] new_q,
  output logic                     sat
);

  localparam int RND_SHIFT = RATE_FRAC_BITS + DT_FRAC_BITS;
  localparam int OUT_SHIFT = RATE_FRAC_BITS + 1;
  localparam logic signed [ACC_W-1:0] ROUND_INIT =
    {{(ACC_W-1){1'b0}}, 1'b1} << RND_SHIFT;

  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [RATE_W-1:0]        low_r, low_nxt;
  logic signed [S_W-1:0]    sreg_r, sreg_nxt;

  logic signed [ACC_W-1:0]  rsum, ssum, rate_acc, delta, wide;
  logic [RATE_W-1:0]        rate_low;
  logic                     ovf;

  function automatic logic signed [ACC_W-1:0] term_val(
    input logic signed [QUAT_W-1:0] q,
    input term_ctl_t                t
  );
    logic signed [ACC_W-1:0] e;
    e = ACC_W'(q);
    if (!t.en) begin
      return '0;
    end
    return t.neg ? -e : e;
  endfunction

  always_comb begin
    rsum     = acc_r + term_val(op_a, term_a) + term_val(op_b, term_b)
               + term_val(op_c, term_c);
    ssum     = acc_r + (ctl.dt_bit ? ACC_W'(sreg_r) : '0);
    rate_acc = rsum >>> 1;
    rate_low = {rsum[0], low_r[RATE_W-1:1]};
    acc_nxt  = acc_r;
    low_nxt  = low_r;
    sreg_nxt = sreg_r;
    if (ctl.clear) begin
      acc_nxt = '0;
      low_nxt = '0;
    end else if (ctl.rate_step) begin
      low_nxt = rate_low;
      if (ctl.rate_last) begin
        sreg_nxt = {rate_acc[S_W-RATE_W-1:0], rate_low};
        acc_nxt  = ROUND_INIT;
      end else begin
        acc_nxt = rate_acc;
      end
    end else if (ctl.scale_step) begin
      acc_nxt = ssum >>> 1;
    end
  end

  always_comb begin
    delta = acc_r >>> OUT_SHIFT;
    wide  = ACC_W'(old_q) + delta;
    ovf   = (wide[ACC_W-1:QUAT_W-1] != {(ACC_W-QUAT_W+1){wide[QUAT_W-1]}});
    sat   = ovf;
    if (ovf) begin
      new_q = wide[ACC_W-1] ? QUAT_MIN : QUAT_MAX;
    end else begin
      new_q = wide[QUAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    low_r  <= low_nxt;
    sreg_r <= sreg_nxt;
  end

endmodule

// ----- sv/quaternion_attitude_integrator_core.sv -----
// Quaternion attitude integrator top level: control, state and output word
//
//   channel | direction | handshake        | word
//   in      | input     | in_valid/stall   | in_word_t  (op, rate_x/y/z)
//   out     | output    | out_valid/stall  | out_word_t (att_w..att_z, saturated)
//   cfg     | input     | cfg_we           | cfg_index, cfg_wdata
//
// Integrate word: the rate bits and then the time-step bits pass through
// the bit-serial lanes, then sum and write.
// Load word: goes straight to the write state. One word in flight; in_stall is high while busy.
// A result waiting on out_stall holds the core in the write state.
// Reset sets identity attitude and the register reset values.
module quaternion_attitude_integrator_core
  import qai_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 30,
  parameter int RATE_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

`include "quaternion_attitude_integrator_core_defines.svh"

  localparam logic signed [QUAT_W-1:0] QUAT_ONE =
    {{(QUAT_W-1){1'b0}}, 1'b1} << QUAT_FRAC_BITS;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [RATE_W-1:0]        rx_r, rx_nxt, ry_r, ry_nxt, rz_r, rz_nxt;
  logic [DT_W-1:0]          dt_r, dt_nxt;
  logic [DT_W-1:0]          time_step_r;
  logic signed [QUAT_W-1:0] init_r [4];
  logic signed [QUAT_W-1:0] att_r [4];
  logic signed [QUAT_W-1:0] att_nxt [4];
  logic                     sat_r, sat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_data_r, out_data_nxt;

  lane_ctl_t                lctl;
  logic signed [QUAT_W-1:0] lane_q [4];
  logic [3:0]               lane_sat;
  logic                     accept, out_free, nt, bx, by, bz;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign nt        = (cnt_r == LAST_STEP);
  assign bx        = rx_r[0];
  assign by        = ry_r[0];
  assign bz        = rz_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RST;
      init_r[0]   <= QUAT_ONE;
      init_r[1]   <= '0;
      init_r[2]   <= '0;
      init_r[3]   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP: time_step_r <= cfg_wdata[DT_W-1:0];
        REG_INIT_W:    init_r[0]   <= cfg_wdata;
        REG_INIT_X:    init_r[1]   <= cfg_wdata;
        REG_INIT_Y:    init_r[2]   <= cfg_wdata;
        REG_INIT_Z:    init_r[3]   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    rz_nxt        = rz_r;
    dt_nxt        = dt_r;
    att_nxt       = att_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    lctl          = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.op) begin
            att_nxt   = init_r;
            sat_nxt   = 1'b0;
            state_nxt = ST_WRITE;
          end else begin
            rx_nxt     = in_data.rate_x;
            ry_nxt     = in_data.rate_y;
            rz_nxt     = in_data.rate_z;
            cnt_nxt    = '0;
            lctl.clear = 1'b1;
            state_nxt  = ST_RATE;
          end
        end
      end
      ST_RATE: begin
        lctl.rate_step = 1'b1;
        lctl.rate_last = nt;
        rx_nxt         = rx_r >> 1;
        ry_nxt         = ry_r >> 1;
        rz_nxt         = rz_r >> 1;
        cnt_nxt        = cnt_r + 1'b1;
        if (nt) begin
          cnt_nxt   = '0;
          dt_nxt    = time_step_r;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        lctl.scale_step = 1'b1;
        lctl.dt_bit     = dt_r[0];
        dt_nxt          = dt_r >> 1;
        cnt_nxt         = cnt_r + 1'b1;
        if (nt) begin
          cnt_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        att_nxt   = lane_q;
        sat_nxt   = |lane_sat;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.att_w     = att_r[0];
          out_data_nxt.att_x     = att_r[1];
          out_data_nxt.att_y     = att_r[2];
          out_data_nxt.att_z     = att_r[3];
          out_data_nxt.saturated = sat_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sat_r       <= 1'b0;
      att_r[0]    <= QUAT_ONE;
      att_r[1]    <= '0;
      att_r[2]    <= '0;
      att_r[3]    <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      sat_r       <= sat_nxt;
      att_r       <= att_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    rz_r       <= rz_nxt;
    dt_r       <= dt_nxt;
    out_data_r <= out_data_nxt;
  end

  // d_w = -x*rx - y*ry - z*rz
  qai_lane #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_lane_w (
    .clk    (clk),
    .ctl    (lctl),
    .op_a   (att_r[1]),
    .op_b   (att_r[2]),
    .op_c   (att_r[3]),
    .term_a ('{en: bx, neg: !nt}),
    .term_b ('{en: by, neg: !nt}),
    .term_c ('{en: bz, neg: !nt}),
    .old_q  (att_r[0]),
    .new_q  (lane_q[0]),
    .sat    (lane_sat[0])
  );

  // d_x = w*rx + y*rz - z*ry
  qai_lane #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_lane_x (
    .clk    (clk),
    .ctl    (lctl),
    .op_a   (att_r[0]),
    .op_b   (att_r[2]),
    .op_c   (att_r[3]),
    .term_a ('{en: bx, neg: nt}),
    .term_b ('{en: bz, neg: nt}),
    .term_c ('{en: by, neg: !nt}),
    .old_q  (att_r[1]),
    .new_q  (lane_q[1]),
    .sat    (lane_sat[1])
  );

  // d_y = w*ry + z*rx - x*rz
  qai_lane #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_lane_y (
    .clk    (clk),
    .ctl    (lctl),
    .op_a   (att_r[0]),
    .op_b   (att_r[3]),
    .op_c   (att_r[1]),
    .term_a ('{en: by, neg: nt}),
    .term_b ('{en: bx, neg: nt}),
    .term_c ('{en: bz, neg: !nt}),
    .old_q  (att_r[2]),
    .new_q  (lane_q[2]),
    .sat    (lane_sat[2])
  );

  // d_z = w*rz + x*ry - y*rx
  qai_lane #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_lane_z (
    .clk    (clk),
    .ctl    (lctl),
    .op_a   (att_r[0]),
    .op_b   (att_r[1]),
    .op_c   (att_r[2]),
    .term_a ('{en: bz, neg: nt}),
    .term_b ('{en: by, neg: nt}),
    .term_c ('{en: bx, neg: !nt}),
    .old_q  (att_r[3]),
    .new_q  (lane_q[3]),
    .sat    (lane_sat[3])
  );

  `QAI_ASSERT_NEXT(a_go_rate, accept && !in_data.op, state_r == ST_RATE && cnt_r == '0)
  `QAI_ASSERT_NEXT(a_load, accept && in_data.op, state_r == ST_WRITE && !sat_r)
  `QAI_ASSERT_NEXT(a_result, state_r == ST_WRITE && out_free, out_valid_r && state_r == ST_IDLE)
  `QAI_ASSERT_NOW(a_busy, state_r == ST_RATE || state_r == ST_SCALE, cnt_r <= LAST_STEP && in_stall)

endmodule

// ----- tb/sv/qai_tb_pkg.sv -----
`timescale 1ns / 100ps
// Item codes shared by the attitude integrator checker and stimulus
package qai_tb_pkg;

  localparam logic OP_INTEGRATE = 1'b0;
  localparam logic OP_LOAD      = 1'b1;

  localparam logic [2:0] REG_NONE = 3'd7;

endpackage

// ----- tb/sv/qai_attitude_checker.sv -----
`timescale 1ns / 100ps
// Attitude predictor and result-word checker for the quaternion attitude integrator
module qai_attitude_checker
  import qai_pkg::*;
  import qai_tb_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 30,
  parameter int RATE_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   pending
);

  localparam int DELTA_SHIFT = RATE_FRAC_BITS + DT_FRAC_BITS + 1;

  logic [DT_W-1:0]          step_dt;
  logic signed [QUAT_W-1:0] init_att [4];
  logic signed [QUAT_W-1:0] att [4];
  out_word_t                expected_att_q [$];
  int                       n_bad;

  function automatic out_word_t advance_attitude(in_word_t w);
    logic signed [63:0]  rate [3];
    logic signed [63:0]  q [4];
    logic signed [63:0]  deriv [4];
    logic signed [127:0] dt_wide;
    logic signed [127:0] delta;
    logic signed [127:0] sum;
    logic                clipped;
    out_word_t           r;
    clipped = 1'b0;
    if (w.op == OP_LOAD) begin
      for (int i = 0; i < 4; i++) att[i] = init_att[i];
    end else begin
      rate[0] = w.rate_x;
      rate[1] = w.rate_y;
      rate[2] = w.rate_z;
      for (int i = 0; i < 4; i++) q[i] = att[i];
      deriv[0] = -q[1] * rate[0] - q[2] * rate[1] - q[3] * rate[2];
      deriv[1] =  q[0] * rate[0] + q[2] * rate[2] - q[3] * rate[1];
      deriv[2] =  q[0] * rate[1] + q[3] * rate[0] - q[1] * rate[2];
      deriv[3] =  q[0] * rate[2] + q[1] * rate[1] - q[2] * rate[0];
      dt_wide = $signed({104'd0, step_dt});
      for (int i = 0; i < 4; i++) begin
        delta = (deriv[i] * dt_wide + (128'sd1 <<< (DELTA_SHIFT - 1))) >>> DELTA_SHIFT;
        sum = q[i] + delta;
        if (sum > QUAT_MAX) begin
          att[i] = QUAT_MAX;
          clipped = 1'b1;
        end else if (sum < QUAT_MIN) begin
          att[i] = QUAT_MIN;
          clipped = 1'b1;
        end else begin
          att[i] = sum[QUAT_W-1:0];
        end
      end
    end
    r.att_w = att[0];
    r.att_x = att[1];
    r.att_y = att[2];
    r.att_z = att[3];
    r.saturated = clipped;
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (!rst_n) begin
      step_dt = TIME_STEP_RST;
      init_att[0] = 32'sd1 <<< QUAT_FRAC_BITS;
      att[0] = 32'sd1 <<< QUAT_FRAC_BITS;
      for (int i = 1; i < 4; i++) begin
        init_att[i] = '0;
        att[i] = '0;
      end
      expected_att_q.delete();
      n_bad = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP: step_dt = cfg_wdata[DT_W-1:0];
          REG_INIT_W:    init_att[0] = cfg_wdata;
          REG_INIT_X:    init_att[1] = cfg_wdata;
          REG_INIT_Y:    init_att[2] = cfg_wdata;
          REG_INIT_Z:    init_att[3] = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_att_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: result word with none pending: w=%h x=%h y=%h z=%h sat=%b",
                     $time, got.att_w, got.att_x, got.att_y, got.att_z, got.saturated);
        end else begin
          want = expected_att_q.pop_front();
          if (got.att_w !== want.att_w || got.att_x !== want.att_x ||
              got.att_y !== want.att_y || got.att_z !== want.att_z ||
              got.saturated !== want.saturated) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: attitude mismatch, expected w=%h x=%h y=%h z=%h sat=%b",
                       $time, want.att_w, want.att_x, want.att_y, want.att_z,
                       want.saturated);
              $display("%0t:                    actual   w=%h x=%h y=%h z=%h sat=%b",
                       $time, got.att_w, got.att_x, got.att_y, got.att_z, got.saturated);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        expected_att_q.push_back(advance_attitude(in_data));
    end
    mismatches <= n_bad;
    pending <= expected_att_q.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Stimulus, clocking and verdict for the quaternion attitude integrator testbench
module tb;
  import qai_pkg::*;
  import qai_tb_pkg::*;

  localparam logic signed [RATE_W-1:0] RATE_MAX = 24'sh7F_FFFF;
  localparam logic signed [RATE_W-1:0] RATE_MIN = 24'sh80_0000;
  localparam logic signed [RATE_W-1:0] RATE_ONE = 24'sh01_0000;
  localparam logic signed [QUAT_W-1:0] QUAT_HALF = 32'sh2000_0000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int                   mismatches;
  int                   pending;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  quaternion_attitude_integrator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  qai_attitude_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic signed [RATE_W-1:0] pick_rate();
    int r;
    if ($urandom_range(3) == 0)
      r = $urandom;
    else
      r = int'($urandom_range(0, 524288)) - 262144;
    return r[RATE_W-1:0];
  endfunction

  function automatic logic [CFG_W-1:0] pick_dt();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'h00FF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_att();
    if ($urandom_range(3) == 0)
      return $urandom;
    return int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
  endfunction

  function automatic in_word_t rate_word(logic op, logic signed [RATE_W-1:0] rx,
                                         logic signed [RATE_W-1:0] ry,
                                         logic signed [RATE_W-1:0] rz);
    in_word_t w;
    w.op = op;
    w.rate_x = rx;
    w.rate_y = ry;
    w.rate_z = rz;
    return w;
  endfunction

  function automatic in_word_t gyro_word(logic op);
    return rate_word(op, pick_rate(), pick_rate(), pick_rate());
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_inits(logic [CFG_W-1:0] w, logic [CFG_W-1:0] x,
                             logic [CFG_W-1:0] y, logic [CFG_W-1:0] z);
    write_reg(REG_INIT_W, w);
    write_reg(REG_INIT_X, x);
    write_reg(REG_INIT_Y, y);
    write_reg(REG_INIT_Z, z);
  endtask

  initial begin
    int idle_by_phase [4];
    int stall_by_phase [4];
    idle_by_phase = '{0, 78, 0, 20};
    stall_by_phase = '{0, 0, 78, 20};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings
    send_word(rate_word(OP_INTEGRATE, '0, '0, '0));
    send_word(rate_word(OP_INTEGRATE, RATE_MAX, RATE_MIN, RATE_ONE));
    send_word(rate_word(OP_INTEGRATE, RATE_MIN, RATE_MAX, -RATE_ONE));
    send_word(gyro_word(OP_LOAD));
    send_word(rate_word(OP_INTEGRATE, RATE_ONE, -RATE_ONE, RATE_ONE >>> 1));

    // largest step from the positive corner, saturates
    wait_drained();
    write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
    write_inits(QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX);
    write_reg(REG_NONE, $urandom);
    send_word(rate_word(OP_LOAD, RATE_MAX, RATE_MAX, RATE_MAX));
    send_word(rate_word(OP_INTEGRATE, RATE_MAX, RATE_MAX, RATE_MAX));
    send_word(rate_word(OP_INTEGRATE, RATE_MIN, RATE_MIN, RATE_MIN));
    send_word(rate_word(OP_LOAD, RATE_MIN, RATE_MIN, RATE_MIN));

    // negative corner
    wait_drained();
    write_inits(QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN);
    send_word(rate_word(OP_LOAD, '0, '0, '0));
    send_word(rate_word(OP_INTEGRATE, RATE_MAX, RATE_MIN, RATE_MAX));
    send_word(rate_word(OP_INTEGRATE, RATE_MIN, RATE_MAX, RATE_MIN));

    // zero step holds the attitude
    wait_drained();
    write_reg(REG_TIME_STEP, '0);
    write_inits(QUAT_HALF, -QUAT_HALF, QUAT_HALF, -QUAT_HALF);
    send_word(rate_word(OP_LOAD, RATE_MAX, RATE_MAX, RATE_MAX));
    send_word(rate_word(OP_INTEGRATE, RATE_MAX, RATE_MIN, RATE_MAX));
    send_word(rate_word(OP_INTEGRATE, RATE_MIN, RATE_MAX, RATE_MIN));

    // smallest nonzero step
    wait_drained();
    write_reg(REG_TIME_STEP, 32'd1);
    send_word(rate_word(OP_INTEGRATE, RATE_MAX, RATE_MAX, RATE_MAX));
    send_word(gyro_word(OP_INTEGRATE));

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      idle_pct = idle_by_phase[ph];
      stall_pct <= stall_by_phase[ph];
      write_reg(REG_TIME_STEP, pick_dt());
      write_inits(pick_att(), pick_att(), pick_att(), pick_att());
      send_word(gyro_word(OP_LOAD));
      for (int n = 0; n < 200; n++) begin
        if (n == 100) begin
          wait_drained();
          write_reg(REG_TIME_STEP, pick_dt());
          if (ph == 0)
            hold_req <= hold_req + 1;
        end
        send_word(gyro_word(($urandom_range(7) == 0) ? OP_LOAD : OP_INTEGRATE));
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/qai_pkg.sv
sv/qai_lane.sv
sv/quaternion_attitude_integrator_core.sv
tb/sv/qai_tb_pkg.sv
tb/sv/qai_attitude_checker.sv
tb/sv/tb.sv
